FILE: hw/rtl/pcbd_pkg.sv
`timescale 1ns / 1ps

package pcbd_pkg;

    localparam int IDX_W  = 6;
    localparam int LEN_W  = 5;
    localparam int CODE_W = 16;
    localparam int SYM_W  = 16;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int MAX_CODE_LEN_DEF  = 16;
    localparam int SYMBOL_WIDTH_DEF  = 16;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_BIT  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [IDX_W-1:0]   entry_index;
        logic [LEN_W-1:0]   entry_length;
        logic [CODE_W-1:0]  entry_code;
        logic [SYM_W-1:0]   entry_symbol;
        logic               bit_value;
    } t_in_word;

    typedef struct packed {
        logic [SYM_W-1:0]   symbol;
        logic               error;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic clr_write;
        logic load;
        logic bit_start;
        logic scan_step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_bit;
        logic clr_last;
        logic hit;
        logic done;
        logic at_max;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: hw/rtl/pcbd_if.sv
`timescale 1ns / 1ps

interface pcbd_in_if;
    logic               valid;
    logic               ready;
    pcbd_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pcbd_out_if;
    logic                valid;
    logic                ready;
    pcbd_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/pcbd_ram.sv
`timescale 1ns / 1ps

module pcbd_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/pcbd_ctrl.sv
`timescale 1ns / 1ps

module pcbd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pcbd_pkg::t_dp_sts i_sts,
    output pcbd_pkg::t_dp_cmd o_cmd
);

    pcbd_pkg::t_state r_state;
    pcbd_pkg::t_state n_state;
    logic             result;

    assign result = i_sts.hit || (i_sts.done && i_sts.at_max);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcbd_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pcbd_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = pcbd_pkg::ST_IDLE;
                end
            end
            pcbd_pkg::ST_IDLE: begin
                if (i_in_valid && i_sts.in_bit) begin
                    n_state = pcbd_pkg::ST_SCAN;
                end
            end
            pcbd_pkg::ST_SCAN: begin
                if (result) begin
                    if (i_sts.out_free) begin
                        n_state = pcbd_pkg::ST_IDLE;
                    end
                end else if (i_sts.done) begin
                    n_state = pcbd_pkg::ST_IDLE;
                end
            end
            default: n_state = pcbd_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            pcbd_pkg::ST_CLEAR: begin
                o_cmd.clr_write = 1'b1;
            end
            pcbd_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load      = i_in_valid && !i_sts.in_bit;
                o_cmd.bit_start = i_in_valid && i_sts.in_bit;
            end
            pcbd_pkg::ST_SCAN: begin
                if (result) begin
                    o_cmd.emit = i_sts.out_free;
                end else if (!i_sts.done) begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/pcbd_dp.sv
`timescale 1ns / 1ps

module pcbd_dp #(
    parameter int TABLE_ENTRIES = pcbd_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CODE_LEN  = pcbd_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_WIDTH  = pcbd_pkg::SYMBOL_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pcbd_pkg::t_in_word  i_in_data,
    input  pcbd_pkg::t_dp_cmd   i_cmd,
    output pcbd_pkg::t_dp_sts   o_sts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pcbd_pkg::t_out_word o_out_data
);

    localparam int AW  = $clog2(TABLE_ENTRIES);
    localparam int XW  = (AW > pcbd_pkg::IDX_W) ? AW : pcbd_pkg::IDX_W;
    localparam int PLW = $clog2(MAX_CODE_LEN + 1);
    localparam int LW  = (PLW > pcbd_pkg::LEN_W) ? PLW : pcbd_pkg::LEN_W;
    localparam int CW  = (MAX_CODE_LEN > pcbd_pkg::CODE_W) ? MAX_CODE_LEN : pcbd_pkg::CODE_W;
    localparam int SW  = SYMBOL_WIDTH;
    localparam int EW  = 1 + pcbd_pkg::LEN_W + pcbd_pkg::CODE_W + SW;

    localparam logic [AW-1:0]  LAST_IDX  = AW'(TABLE_ENTRIES - 1);
    localparam logic [XW:0]    ENTRIES_X = (XW + 1)'(TABLE_ENTRIES);
    localparam logic [PLW-1:0] MAX_LEN   = PLW'(MAX_CODE_LEN);

    // entry layout: {valid, length, code, symbol}
    localparam int SYM_LO  = 0;
    localparam int CODE_LO = SW;
    localparam int LEN_LO  = SW + pcbd_pkg::CODE_W;
    localparam int VLD_BIT = SW + pcbd_pkg::CODE_W + pcbd_pkg::LEN_W;

    logic [AW-1:0]           r_idx;
    logic                    r_chk;
    logic                    r_chk_last;
    logic [MAX_CODE_LEN-1:0] r_code;
    logic [PLW-1:0]          r_len;
    logic                    r_out_valid;
    pcbd_pkg::t_out_word     r_out_data;

    logic [XW-1:0]               idx_x;
    logic                        in_range;
    logic [pcbd_pkg::CODE_W-1:0] code_mask;
    logic                        we;
    logic [AW-1:0]               waddr;
    logic [EW-1:0]               wdata;
    logic [EW-1:0]               rdata;

    logic                        e_valid;
    logic [pcbd_pkg::LEN_W-1:0]  e_len;
    logic [pcbd_pkg::CODE_W-1:0] e_code;
    logic [SW-1:0]               e_sym;
    logic                        match;
    logic                        hit;

    assign idx_x    = XW'(i_in_data.entry_index);
    assign in_range = ({1'b0, idx_x} < ENTRIES_X);

    always_comb begin
        for (int k = 0; k < pcbd_pkg::CODE_W; k++) begin
            code_mask[k] = (pcbd_pkg::LEN_W'(k) < i_in_data.entry_length);
        end
    end

    always_comb begin
        if (i_cmd.clr_write) begin
            we    = 1'b1;
            waddr = r_idx;
            wdata = '0;
        end else begin
            we    = i_cmd.load && in_range;
            waddr = idx_x[AW-1:0];
            wdata = {(i_in_data.entry_length != '0),
                     i_in_data.entry_length,
                     i_in_data.entry_code & code_mask,
                     SW'(i_in_data.entry_symbol)};
        end
    end

    pcbd_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.scan_step),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    assign e_valid = rdata[VLD_BIT];
    assign e_len   = rdata[LEN_LO +: pcbd_pkg::LEN_W];
    assign e_code  = rdata[CODE_LO +: pcbd_pkg::CODE_W];
    assign e_sym   = rdata[SYM_LO +: SW];

    assign match = e_valid
                && (LW'(e_len) == LW'(r_len))
                && (CW'(e_code) == CW'(r_code));
    assign hit   = r_chk && match;

    // table index: clearing sweep, then scan address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_chk      <= 1'b0;
            r_chk_last <= 1'b0;
        end else if (i_cmd.clr_write) begin
            r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
        end else if (i_cmd.bit_start) begin
            r_idx      <= '0;
            r_chk      <= 1'b0;
            r_chk_last <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_chk      <= 1'b1;
            r_chk_last <= (r_idx == LAST_IDX);
            if (r_idx != LAST_IDX) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= '0;
            r_len  <= '0;
        end else if (i_cmd.bit_start) begin
            if (MAX_CODE_LEN > 1) begin
                r_code <= {r_code[MAX_CODE_LEN-2:0], i_in_data.bit_value};
            end
            r_len <= r_len + 1'b1;
        end else if (i_cmd.emit) begin
            r_code <= '0;
            r_len  <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data.symbol <= hit ? pcbd_pkg::SYM_W'(e_sym) : '0;
            r_out_data.error  <= !hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_sts.in_bit   = (i_in_data.cmd == pcbd_pkg::CMD_BIT);
    assign o_sts.clr_last = (r_idx == LAST_IDX);
    assign o_sts.hit      = hit;
    assign o_sts.done     = r_chk && r_chk_last;
    assign o_sts.at_max   = (r_len >= MAX_LEN);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

FILE: hw/rtl/prefix_code_bit_decoder_core.sv
`timescale 1ns / 1ps

// Prefix-code bit decoder.
// i_in carries words of two kinds: a load word (cmd = load) writes one
// code table slot (length, code, symbol; length 0 empties the slot), a bit
// word (cmd = bit) shifts one bit into the pending code.
// o_out carries one word {symbol, error} when the pending code matches a
// slot (lowest slot wins) or reaches MAX_CODE_LEN bits with no match.
// Load words are written to the table as they are taken. A bit word scans the
// table one slot a cycle through the RAM read port, stopping early on a match;
// the result register is written at the end of the scan; ready drops for the scan.
// Reset: the table is swept empty, one slot a cycle, with i_in not ready;
// the pending code and the output valid flag are cleared.
// A stalled receiver holds the result register; the next bit word is still
// taken and scanned, and its result waits at the end of the scan until the
// register frees up.

module prefix_code_bit_decoder_core #(
    parameter int TABLE_ENTRIES = pcbd_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CODE_LEN  = pcbd_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_WIDTH  = pcbd_pkg::SYMBOL_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcbd_in_if.sink    i_in,
    pcbd_out_if.source o_out
);

    pcbd_pkg::t_dp_cmd dp_cmd;
    pcbd_pkg::t_dp_sts dp_sts;

    pcbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    pcbd_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_CODE_LEN  (MAX_CODE_LEN),
        .SYMBOL_WIDTH  (SYMBOL_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in.data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data)
    );

endmodule

FILE: tb/sv/prefix_code_bit_decoder_core_tb.sv
`timescale 1ns / 1ps

module prefix_code_bit_decoder_core_tb;
    import pcbd_pkg::*;

    localparam int NUM_SLOTS   = TABLE_ENTRIES_DEF;
    localparam int MAX_LEN     = MAX_CODE_LEN_DEF;
    localparam int PHASE_WORDS = 260;
    localparam int TAIL_CYCLES = 100;
    localparam int HOLD_CYCLES = 3000;
    localparam int CYCLE_LIMIT = 1000000;

    logic i_clk;
    logic i_rst_n;

    pcbd_in_if  in_if ();
    pcbd_out_if out_if ();

    prefix_code_bit_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // mirror of the decoder state
    logic              tbl_valid [NUM_SLOTS];
    logic [LEN_W-1:0]  tbl_len   [NUM_SLOTS];
    logic [CODE_W-1:0] tbl_code  [NUM_SLOTS];
    logic [SYM_W-1:0]  tbl_sym   [NUM_SLOTS];
    logic [CODE_W-1:0] acc_code;
    int                acc_len;

    t_in_word  pending_words [$];
    t_out_word expected_results [$];

    // generator's own view of the loaded prefix code
    bit                gen_used [NUM_SLOTS];
    logic [CODE_W-1:0] gen_code [$];
    int                gen_len  [$];

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    bit rx_hold;
    int cycles;
    int mismatches;
    int results_seen;
    int error_results;
    int loads_in;
    int bits_in;
    int stim_words;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [CODE_W-1:0] len_mask(int len);
        if (len >= CODE_W) return '1;
        return CODE_W'((32'd1 << len) - 1);
    endfunction

    task automatic decode_step(input t_in_word w);
        t_out_word res;
        bit        hit;
        hit = 1'b0;
        res = '0;
        if (w.cmd == CMD_LOAD) begin
            loads_in++;
            tbl_valid[w.entry_index] = (w.entry_length != '0);
            tbl_len[w.entry_index]   = w.entry_length;
            tbl_code[w.entry_index]  = w.entry_code & len_mask(int'(w.entry_length));
            tbl_sym[w.entry_index]   = w.entry_symbol;
        end else begin
            bits_in++;
            acc_code = {acc_code[CODE_W-2:0], w.bit_value};
            acc_len++;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (!hit && tbl_valid[i] && int'(tbl_len[i]) == acc_len
                        && tbl_code[i] == acc_code) begin
                    hit = 1'b1;
                    res.symbol = tbl_sym[i];
                end
            end
            // a match at full length wins over the no-match error
            if (hit || acc_len >= MAX_LEN) begin
                res.error = !hit;
                expected_results.push_back(res);
                acc_code = '0;
                acc_len = 0;
            end
        end
    endtask

    task automatic push_load(int slot, int len, logic [CODE_W-1:0] code,
                             logic [SYM_W-1:0] sym);
        t_in_word w;
        w.cmd          = CMD_LOAD;
        w.entry_index  = IDX_W'(slot);
        w.entry_length = LEN_W'(len);
        w.entry_code   = code;
        w.entry_symbol = sym;
        w.bit_value    = 1'($urandom_range(1));
        pending_words.push_back(w);
        stim_words++;
        gen_used[slot] = (len != 0);
    endtask

    task automatic push_bit(logic b);
        t_in_word w;
        w.cmd          = CMD_BIT;
        w.entry_index  = IDX_W'($urandom);
        w.entry_length = LEN_W'($urandom);
        w.entry_code   = CODE_W'($urandom);
        w.entry_symbol = SYM_W'($urandom);
        w.bit_value    = b;
        pending_words.push_back(w);
        stim_words++;
    endtask

    task automatic push_random_load();
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 10) len = 0;
        else if (r < 70) len = $urandom_range(1, 5);
        else if (r < 90) len = $urandom_range(6, MAX_LEN);
        else len = $urandom_range(MAX_LEN + 1, (1 << LEN_W) - 1);
        push_load($urandom_range(NUM_SLOTS - 1), len, CODE_W'($urandom), SYM_W'($urandom));
    endtask

    // complete prefix code by random leaf splits, then a stream of its codes with stray bits and loads mixed in
    task automatic gen_prefix_epoch();
        int                n;
        int                deep;
        int                splits;
        int                j;
        int                l;
        int                tmp;
        int                pick;
        int                r;
        logic [CODE_W-1:0] c;
        int                order [NUM_SLOTS];
        bit                keep  [NUM_SLOTS];
        gen_code.delete();
        gen_len.delete();
        gen_code.push_back('0);
        gen_len.push_back(1);
        gen_code.push_back(CODE_W'(1));
        gen_len.push_back(1);
        deep = $urandom_range(1);
        n = deep ? $urandom_range(MAX_LEN + 1, 40) : $urandom_range(2, 24);
        splits = 0;
        while (gen_code.size() < n) begin
            // deep tables grow one chain down to full code length first
            if (deep && splits < MAX_LEN - 1) j = gen_code.size() - 1;
            else j = $urandom_range(gen_code.size() - 1);
            if (gen_len[j] < MAX_LEN) begin
                c = gen_code[j];
                l = gen_len[j];
                gen_code[j] = c << 1;
                gen_len[j] = l + 1;
                gen_code.push_back((c << 1) | CODE_W'(1));
                gen_len.push_back(l + 1);
                splits++;
            end
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            order[i] = i;
            keep[i] = 1'b0;
        end
        for (int i = NUM_SLOTS - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < n; k++) keep[order[k]] = 1'b1;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (gen_used[s] && !keep[s]) push_load(s, 0, CODE_W'($urandom), SYM_W'($urandom));
        end
        for (int k = 0; k < n; k++) begin
            push_load(order[k], gen_len[k],
                      gen_code[k] | (CODE_W'($urandom) & ~len_mask(gen_len[k])),
                      SYM_W'($urandom));
        end
        repeat ($urandom_range(10, 40)) begin
            r = $urandom_range(99);
            if (r < 4) push_bit(1'($urandom_range(1)));
            else if (r < 7) push_random_load();
            pick = $urandom_range(n - 1);
            for (int b = gen_len[pick] - 1; b >= 0; b--) push_bit(gen_code[pick][b]);
        end
    endtask

    task automatic gen_sparse_epoch();
        repeat ($urandom_range(4, 20)) push_random_load();
        repeat ($urandom_range(20, 80)) push_bit(1'($urandom_range(1)));
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || in_if.valid || expected_results.size() != 0);
    endtask

    task automatic note_failure(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) decode_step(in_if.data);
            if (!in_if.valid || in_if.ready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_if.valid <= 1'b1;
                    in_if.data  <= pending_words.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : out_monitor
        t_out_word want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                if (out_if.data.error) error_results++;
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("unexpected word: symbol %h error %b",
                                           out_if.data.symbol, out_if.data.error));
                end else begin
                    want = expected_results.pop_front();
                    if (out_if.data.symbol !== want.symbol || out_if.data.error !== want.error)
                        note_failure($sformatf(
                            "word %0d: symbol %h error %b, expected symbol %h error %b",
                            results_seen, out_if.data.symbol, out_if.data.error,
                            want.symbol, want.error));
                end
            end
            out_if.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        wait (hold_req);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycles, expected_results.size());
            $display("prefix_code_bit_decoder_core_tb failed");
            $finish;
        end
    end

    initial begin
        int phase_start;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        acc_code = '0;
        acc_len = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_len[i] = '0;
            tbl_code[i] = '0;
            tbl_sym[i] = '0;
        end

        // empty table: full-length code with no match
        for (int i = 0; i < MAX_LEN; i++) push_bit(logic'(i % 2 == 0));
        // same 1-bit code in two slots, high code bits set, overlong slot
        push_load(NUM_SLOTS - 1, 1, 16'hFFFE, 16'hFFFF);
        push_load(9, 1, 16'h0000, 16'h1234);
        push_load(0, (1 << LEN_W) - 1, 16'hFFFF, 16'hBEEF);
        push_load(2, 2, 16'h0003, 16'h8001);
        push_bit(1'b0);
        push_load(9, 0, 16'hFFFF, 16'hFFFF);
        push_bit(1'b0);
        push_bit(1'b1);
        push_bit(1'b1);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 49 : 0;
            recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 10 : 0;
            phase_start = stim_words;
            while (stim_words - phase_start < PHASE_WORDS) begin
                if ($urandom_range(9) < 7) gen_prefix_epoch();
                else gen_sparse_epoch();
            end
            if (ph == 2) hold_req = 1'b1;
            wait_drained();
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("decoded %0d code bits against %0d table loads: %0d words checked, %0d no-match",
                 bits_in, loads_in, results_seen, error_results);
        $display("stall mixes 10/49, 49/10 and none, plus a %0d-cycle output hold; %0d mismatches",
                 HOLD_CYCLES, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("prefix_code_bit_decoder_core_tb passed");
        end else begin
            $display("prefix_code_bit_decoder_core_tb failed");
        end
        $finish;
    end

endmodule
